@@ src/gbop_pkg.sv @@
// ----------------------------------------------------------------------------
// gbop_pkg
// Types and constants shared by the buffer offset planner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gbop_pkg;

  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned STEP_W  = 10;
  localparam int unsigned OFF_W   = 39;
  localparam int unsigned WIDE_W  = 40;
  localparam int unsigned ASIZE_W = 33;
  localparam int unsigned INDEX_W = 6;

  typedef struct packed {
    logic [SIZE_W-1:0] size_bytes;
    logic [STEP_W-1:0] birth_step;
    logic [STEP_W-1:0] death_step;
    logic              view_flag;
    logic              last_item;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] buffer_index;
    logic [OFF_W-1:0]   byte_offset;
    logic               placed;
    logic [OFF_W-1:0]   peak_bytes;
    logic               fits;
    logic               dropped;
    logic               last_result;
  } out_t;

  // Descriptor after the front end has worked out its aligned size.
  typedef struct packed {
    in_t                item;
    logic [ASIZE_W-1:0] asize;
  } work_t;

  // One entry of the buffer store, without its load-order index.
  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [STEP_W-1:0]  birth;
    logic [STEP_W-1:0]  death;
    logic               view;
    logic [ASIZE_W-1:0] asize;
  } entry_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_MUL,
    FR_SUB,
    FR_FIX,
    FR_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    EN_LOAD,
    EN_S_I,
    EN_S_IRD,
    EN_S_J,
    EN_S_JRD,
    EN_P_I,
    EN_P_IRD,
    EN_P_J,
    EN_P_JRD,
    EN_O_K,
    EN_O_KRD
  } eng_state_e;

endpackage

`default_nettype wire

@@ src/gbop_ram.sv @@
// ----------------------------------------------------------------------------
// gbop_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gbop_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ src/gbop_fifo.sv @@
// ----------------------------------------------------------------------------
// gbop_fifo
// Small synchronous queue of flip-flops used between the planner stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gbop_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output logic      [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ src/gbop_front.sv @@
// ----------------------------------------------------------------------------
// gbop_front
// Accepts descriptors and works out each size rounded up to the alignment.
// ----------------------------------------------------------------------------
`default_nettype none

module gbop_front #(
  parameter int unsigned ALIGN_BYTES = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire gbop_pkg::in_t   item_i,
  input  wire logic            wk_full_i,
  output logic                 wk_push_o,
  output gbop_pkg::work_t      wk_data_o
);

  localparam int unsigned LB      = $clog2(ALIGN_BYTES);
  localparam int unsigned SHIFT   = 31 + LB;
  // The raw remainder stays below three times the alignment.
  localparam int unsigned RW      = LB + 2;
  // Scaled reciprocal of the alignment; it always fits in 32 bits.
  localparam logic [63:0] RECIP   = (64'd1 << SHIFT) / 64'(ALIGN_BYTES);
  localparam logic [31:0] RECIP32 = RECIP[31:0];

  gbop_pkg::front_state_e       state_q, state_d;
  gbop_pkg::in_t                item_q;
  logic [63:0]                  prod_q, prod_d;
  logic [RW-1:0]                rem_q, rem_d;
  logic [RW-1:0]                rem_once;
  logic [31:0]                  quot, quot_a;
  logic                         load;

  assign quot     = 32'(prod_q >> SHIFT);
  assign quot_a   = quot * 32'(ALIGN_BYTES);
  assign rem_once = (rem_q >= RW'(ALIGN_BYTES)) ? rem_q - RW'(ALIGN_BYTES) : rem_q;

  assign wk_data_o.item  = item_q;
  assign wk_data_o.asize = (rem_q == '0)
      ? {1'b0, item_q.size_bytes}
      : {1'b0, item_q.size_bytes} + gbop_pkg::ASIZE_W'(ALIGN_BYTES)
        - gbop_pkg::ASIZE_W'(rem_q);

  always_comb begin
    state_d   = state_q;
    prod_d    = prod_q;
    rem_d     = rem_q;
    full_o    = 1'b1;
    wk_push_o = 1'b0;
    load      = 1'b0;
    unique case (state_q)
      gbop_pkg::FR_IDLE: begin
        full_o = 1'b0;
        if (push_i) begin
          load    = 1'b1;
          state_d = gbop_pkg::FR_MUL;
        end
      end
      gbop_pkg::FR_MUL: begin
        prod_d  = {32'd0, item_q.size_bytes} * {32'd0, RECIP32};
        state_d = gbop_pkg::FR_SUB;
      end
      gbop_pkg::FR_SUB: begin
        // The quotient estimate is low by at most two.
        rem_d   = RW'(item_q.size_bytes - quot_a);
        state_d = gbop_pkg::FR_FIX;
      end
      gbop_pkg::FR_FIX: begin
        rem_d   = (rem_once >= RW'(ALIGN_BYTES)) ? rem_once - RW'(ALIGN_BYTES) : rem_once;
        state_d = gbop_pkg::FR_PUSH;
      end
      gbop_pkg::FR_PUSH: begin
        if (!wk_full_i) begin
          wk_push_o = 1'b1;
          state_d   = gbop_pkg::FR_IDLE;
        end
      end
      default: state_d = gbop_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbop_pkg::FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
    if (load) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ src/gbop_engine.sv @@
// ----------------------------------------------------------------------------
// gbop_engine
// Stores descriptors, sorts them by size, places them and emits the results.
// ----------------------------------------------------------------------------
`default_nettype none

module gbop_engine #(
  parameter int unsigned MAX_BUFFERS = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       wk_empty_i,
  input  wire gbop_pkg::work_t            wk_data_i,
  output logic                            wk_pop_o,
  input  wire logic                       res_full_i,
  output logic                            res_push_o,
  output gbop_pkg::out_t                  res_data_o,
  input  wire logic [gbop_pkg::OFF_W-1:0] capacity_i
);

  localparam int unsigned IW = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int unsigned CW = $clog2(MAX_BUFFERS + 1);
  localparam int unsigned EW = $bits(gbop_pkg::entry_t);

  gbop_pkg::eng_state_e          state_q, state_d;
  logic [CW-1:0]                 cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic                          ovf_q, ovf_d;
  gbop_pkg::entry_t              cur_q, cur_d;
  logic [IW-1:0]                 org_q, org_d;
  logic [gbop_pkg::WIDE_W-1:0]   off_q, off_d, peak_q, peak_d;

  logic                          ent_we, off_we;
  logic [IW-1:0]                 ent_waddr, off_waddr, raddr;
  logic [IW+EW-1:0]              ent_wdata, ent_rdata;
  logic [gbop_pkg::OFF_W-1:0]    off_wdata, off_rdata;
  gbop_pkg::entry_t              rd_ent, ld_ent;
  logic [IW-1:0]                 rd_org;

  logic                          rd_takes, live, clash;
  logic [gbop_pkg::WIDE_W-1:0]   j_end, i_end, oj;

  assign rd_ent = gbop_pkg::entry_t'(ent_rdata[EW-1:0]);
  assign rd_org = ent_rdata[IW+EW-1:EW];

  assign ld_ent.size  = wk_data_i.item.size_bytes;
  assign ld_ent.birth = wk_data_i.item.birth_step;
  assign ld_ent.death = wk_data_i.item.death_step;
  assign ld_ent.view  = wk_data_i.item.view_flag;
  assign ld_ent.asize = wk_data_i.asize;

  assign rd_takes  = !rd_ent.view && (rd_ent.size != '0);
  assign live      = (cur_q.birth <= rd_ent.death) && (rd_ent.birth <= cur_q.death);
  assign oj        = {1'b0, off_rdata};
  assign j_end     = oj + gbop_pkg::WIDE_W'(rd_ent.size);
  assign i_end     = off_q + gbop_pkg::WIDE_W'(cur_q.size);
  assign clash     = rd_takes && live && (off_q < j_end) && (oj < i_end);

  gbop_ram #(.WIDTH(IW + EW), .DEPTH(MAX_BUFFERS)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (raddr),
    .rdata_o (ent_rdata)
  );

  gbop_ram #(.WIDTH(gbop_pkg::OFF_W), .DEPTH(MAX_BUFFERS)) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (off_waddr),
    .wdata_i (off_wdata),
    .raddr_i (raddr),
    .rdata_o (off_rdata)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    i_d        = i_q;
    j_d        = j_q;
    ovf_d      = ovf_q;
    cur_d      = cur_q;
    org_d      = org_q;
    off_d      = off_q;
    peak_d     = peak_q;
    wk_pop_o   = 1'b0;
    res_push_o = 1'b0;
    ent_we     = 1'b0;
    ent_waddr  = i_q[IW-1:0];
    ent_wdata  = {org_q, cur_q};
    off_we     = 1'b0;
    off_waddr  = i_q[IW-1:0];
    off_wdata  = off_q[gbop_pkg::OFF_W-1:0];
    raddr      = i_q[IW-1:0];

    res_data_o.buffer_index = gbop_pkg::INDEX_W'(rd_org);
    res_data_o.byte_offset  = rd_takes ? off_rdata : '0;
    res_data_o.placed       = rd_takes;
    res_data_o.peak_bytes   = peak_q[gbop_pkg::OFF_W-1:0];
    res_data_o.fits         = (peak_q[gbop_pkg::OFF_W-1:0] <= capacity_i);
    res_data_o.dropped      = ovf_q;
    res_data_o.last_result  = ((i_q + CW'(1)) == cnt_q);

    unique case (state_q)
      gbop_pkg::EN_LOAD: begin
        if (!wk_empty_i) begin
          wk_pop_o = 1'b1;
          if (cnt_q < CW'(MAX_BUFFERS)) begin
            ent_we    = 1'b1;
            ent_waddr = cnt_q[IW-1:0];
            ent_wdata = {cnt_q[IW-1:0], ld_ent};
            cnt_d     = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (wk_data_i.item.last_item) begin
            i_d     = '0;
            peak_d  = '0;
            state_d = gbop_pkg::EN_S_I;
          end
        end
      end
      // Selection pass: the entry at slot i is held in cur and swapped with
      // every larger later non-view entry; the slot gets its final entry at the end.
      gbop_pkg::EN_S_I: begin
        if (i_q == cnt_q) begin
          i_d     = '0;
          state_d = gbop_pkg::EN_P_I;
        end else begin
          state_d = gbop_pkg::EN_S_IRD;
        end
      end
      gbop_pkg::EN_S_IRD: begin
        cur_d = rd_ent;
        org_d = rd_org;
        if (rd_ent.view) begin
          i_d     = i_q + CW'(1);
          state_d = gbop_pkg::EN_S_I;
        end else begin
          j_d     = i_q + CW'(1);
          state_d = gbop_pkg::EN_S_J;
        end
      end
      gbop_pkg::EN_S_J: begin
        raddr = j_q[IW-1:0];
        if (j_q == cnt_q) begin
          ent_we  = 1'b1;
          i_d     = i_q + CW'(1);
          state_d = gbop_pkg::EN_S_I;
        end else begin
          state_d = gbop_pkg::EN_S_JRD;
        end
      end
      gbop_pkg::EN_S_JRD: begin
        if (!rd_ent.view && (rd_ent.size > cur_q.size)) begin
          ent_we    = 1'b1;
          ent_waddr = j_q[IW-1:0];
          cur_d     = rd_ent;
          org_d     = rd_org;
        end
        j_d     = j_q + CW'(1);
        state_d = gbop_pkg::EN_S_J;
      end
      gbop_pkg::EN_P_I: begin
        if (i_q == cnt_q) begin
          i_d     = '0;
          state_d = gbop_pkg::EN_O_K;
        end else begin
          state_d = gbop_pkg::EN_P_IRD;
        end
      end
      gbop_pkg::EN_P_IRD: begin
        cur_d = rd_ent;
        if (!rd_takes) begin
          off_we    = 1'b1;
          off_wdata = '0;
          i_d       = i_q + CW'(1);
          state_d   = gbop_pkg::EN_P_I;
        end else begin
          off_d   = '0;
          j_d     = '0;
          state_d = gbop_pkg::EN_P_J;
        end
      end
      gbop_pkg::EN_P_J: begin
        raddr = j_q[IW-1:0];
        if (j_q == i_q) begin
          off_we = 1'b1;
          if (i_end > peak_q) begin
            peak_d = i_end;
          end
          i_d     = i_q + CW'(1);
          state_d = gbop_pkg::EN_P_I;
        end else begin
          state_d = gbop_pkg::EN_P_JRD;
        end
      end
      gbop_pkg::EN_P_JRD: begin
        // A conflict moves the candidate past the other buffer and rescans.
        if (clash) begin
          off_d = oj + gbop_pkg::WIDE_W'(rd_ent.asize);
          j_d   = '0;
        end else begin
          j_d = j_q + CW'(1);
        end
        state_d = gbop_pkg::EN_P_J;
      end
      gbop_pkg::EN_O_K: begin
        if (i_q == cnt_q) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = gbop_pkg::EN_LOAD;
        end else if (!res_full_i) begin
          state_d = gbop_pkg::EN_O_KRD;
        end
      end
      gbop_pkg::EN_O_KRD: begin
        res_push_o = 1'b1;
        i_d        = i_q + CW'(1);
        state_d    = gbop_pkg::EN_O_K;
      end
      default: state_d = gbop_pkg::EN_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbop_pkg::EN_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    org_q  <= org_d;
    off_q  <= off_d;
    peak_q <= peak_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cnt_q <= CW'(MAX_BUFFERS))
    else $error("buffer store count above depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
      res_push_o |-> !res_full_i)
    else $error("result word pushed into a full queue");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(ovf_q) |-> ($past(cnt_q) == CW'(MAX_BUFFERS)))
    else $error("overflow flagged while the store had room");

  a_pop_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
      wk_pop_o |-> (state_q == gbop_pkg::EN_LOAD))
    else $error("descriptor taken while planning");

endmodule

`default_nettype wire

@@ src/greedy_buffer_offset_planner_unit.sv @@
// A descriptor passes the alignment unit's multiply, subtract, fix-up and push states and
// a two-entry queue before it is stored; the alignment unit takes a new descriptor only
// once it has pushed the last one. After the last descriptor the engine runs a sort pass,
// a placement scan of each entry i against the entries before it (restarted after each conflict), then emits the words.
// Reset clears the control state and sets the capacity to all ones; the buffer
// store is not cleared.
// ----------------------------------------------------------------------------
// greedy_buffer_offset_planner_unit
// Greedy-by-size arena offset planner with a queue interface and an APB port.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_buffer_offset_planner_unit #(
  parameter int unsigned MAX_BUFFERS = 64,
  parameter int unsigned ALIGN_BYTES = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire gbop_pkg::in_t  in_word_i,
  output logic                empty,
  input  wire logic           pop,
  output gbop_pkg::out_t      out_word_o,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [3:0]     paddr,
  input  wire logic [63:0]    pwdata,
  output logic      [63:0]    prdata,
  output logic                pready
);

  localparam int unsigned WK_W  = $bits(gbop_pkg::work_t);
  localparam int unsigned RES_W = $bits(gbop_pkg::out_t);

  logic [gbop_pkg::OFF_W-1:0] cap_q;
  logic                       wk_push, wk_full, wk_pop, wk_empty;
  logic                       res_push, res_full;
  gbop_pkg::work_t            wk_in, wk_out;
  gbop_pkg::out_t             res_in;
  logic [WK_W-1:0]            wk_raw;
  logic [RES_W-1:0]           res_raw;
  logic                       cap_sel;

  assign pready  = 1'b1;
  assign cap_sel = (paddr[3] == 1'b0);
  assign prdata  = cap_sel ? {{(64 - gbop_pkg::OFF_W){1'b0}}, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '1;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      cap_q <= pwdata[gbop_pkg::OFF_W-1:0];
    end
  end

  gbop_front #(.ALIGN_BYTES(ALIGN_BYTES)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .item_i    (in_word_i),
    .wk_full_i (wk_full),
    .wk_push_o (wk_push),
    .wk_data_o (wk_in)
  );

  gbop_fifo #(.WIDTH(WK_W), .DEPTH(2)) u_wk_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wk_push),
    .full_o  (wk_full),
    .wdata_i (wk_in),
    .pop_i   (wk_pop),
    .empty_o (wk_empty),
    .rdata_o (wk_raw)
  );

  assign wk_out = gbop_pkg::work_t'(wk_raw);

  gbop_engine #(.MAX_BUFFERS(MAX_BUFFERS)) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wk_empty_i (wk_empty),
    .wk_data_i  (wk_out),
    .wk_pop_o   (wk_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_data_o (res_in),
    .capacity_i (cap_q)
  );

  gbop_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (res_raw)
  );

  assign out_word_o = gbop_pkg::out_t'(res_raw);

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives descriptor batches into the offset planner and checks every plan
// word against an in-bench greedy-by-size placement model, across several
// arena capacities, with random stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned ALIGN      = 16;
  localparam logic [3:0]  ADDR_ARENA = 4'd0;
  localparam logic [38:0] CAP_MAX    = {39{1'b1}};

  class planner_scoreboard;
    logic [31:0] sz   [DEPTH];
    logic [9:0]  born [DEPTH];
    logic [9:0]  dies [DEPTH];
    logic        view [DEPTH];
    logic [5:0]  origin [DEPTH];
    logic [38:0] offs [DEPTH];
    int unsigned count;
    logic        overflow;
    logic [38:0] capacity;
    gbop_pkg::out_t plan_words[$];
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned batches;

    function new();
      count = 0;
      overflow = 1'b0;
      capacity = CAP_MAX;
      mismatches = 0;
      words_checked = 0;
      batches = 0;
    endfunction

    function bit has_storage(int unsigned k);
      return !view[k] && sz[k] != 0;
    endfunction

    function longint unsigned round_to_align(longint unsigned v);
      return ((v + ALIGN - 1) / ALIGN) * ALIGN;
    endfunction

    function void swap_slots(int unsigned x, int unsigned y);
      logic [31:0] s;
      logic [9:0]  b, d;
      logic        v;
      logic [5:0]  o;
      logic [38:0] f;
      s = sz[x];     sz[x] = sz[y];         sz[y] = s;
      b = born[x];   born[x] = born[y];     born[y] = b;
      d = dies[x];   dies[x] = dies[y];     dies[y] = d;
      v = view[x];   view[x] = view[y];     view[y] = v;
      o = origin[x]; origin[x] = origin[y]; origin[y] = o;
      f = offs[x];   offs[x] = offs[y];     offs[y] = f;
    endfunction

    function void plan_batch();
      longint unsigned peak, off, j_end, i_end;
      bit clash;
      gbop_pkg::out_t w;
      peak = 0;
      for (int unsigned i = 0; i < count; i++) begin
        if (view[i]) continue;
        for (int unsigned j = i + 1; j < count; j++)
          if (!view[j] && sz[j] > sz[i]) swap_slots(i, j);
      end
      for (int unsigned i = 0; i < count; i++) begin
        if (!has_storage(i)) begin
          offs[i] = '0;
          continue;
        end
        off = 0;
        // Restart the scan from the aligned end of whichever buffer clashed.
        do begin
          off = round_to_align(off);
          clash = 1'b0;
          for (int unsigned j = 0; j < i; j++) begin
            if (!has_storage(j)) continue;
            if (!(born[i] <= dies[j] && born[j] <= dies[i])) continue;
            j_end = longint'(offs[j]) + sz[j];
            i_end = off + sz[i];
            if (off < j_end && offs[j] < i_end) begin
              off = round_to_align(j_end);
              clash = 1'b1;
              break;
            end
          end
        end while (clash);
        offs[i] = off[38:0];
        if (off + sz[i] > peak) peak = off + sz[i];
      end
      for (int unsigned k = 0; k < count; k++) begin
        w.buffer_index = origin[k];
        w.byte_offset  = has_storage(k) ? offs[k] : '0;
        w.placed       = has_storage(k);
        w.peak_bytes   = peak[38:0];
        w.fits         = (peak[38:0] <= capacity);
        w.dropped      = overflow;
        w.last_result  = (k + 1 == count);
        plan_words.push_back(w);
      end
      batches++;
      count = 0;
      overflow = 1'b0;
    endfunction

    function void note_descriptor(gbop_pkg::in_t d);
      if (count < DEPTH) begin
        sz[count]     = d.size_bytes;
        born[count]   = d.birth_step;
        dies[count]   = d.death_step;
        view[count]   = d.view_flag;
        origin[count] = count[5:0];
        offs[count]   = '0;
        count++;
      end else begin
        overflow = 1'b1;
      end
      if (d.last_item) plan_batch();
    endfunction

    function void check_word(gbop_pkg::out_t got);
      gbop_pkg::out_t want;
      words_checked++;
      if (plan_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected plan word %p", got);
        return;
      end
      want = plan_words.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("plan word mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           push = 1'b0;
  logic           full;
  gbop_pkg::in_t  in_word_i = '0;
  logic           empty;
  logic           pop = 1'b0;
  gbop_pkg::out_t out_word_o;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [3:0]     paddr = '0;
  logic [63:0]    pwdata = '0;
  logic [63:0]    prdata;
  logic           pready;

  planner_scoreboard plan_sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  int unsigned descriptors_sent = 0;

  always #1 clk_i = ~clk_i;

  greedy_buffer_offset_planner_unit i_dut (
    .clk_i, .rst_ni, .push, .full, .in_word_i, .empty, .pop, .out_word_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    #4000000;
    $display("timeout with words still outstanding");
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_descriptor(gbop_pkg::in_t d);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    push <= 1'b1;
    in_word_i <= d;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    plan_sb.note_descriptor(d);
    descriptors_sent++;
  endtask

  task automatic write_arena(logic [38:0] cap);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= ADDR_ARENA;
    pwdata <= {25'd0, cap};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    plan_sb.capacity = cap;
  endtask

  // Waits until every plan word has come back, then lets the block settle.
  task automatic drain_plans();
    push <= 1'b0;
    @(posedge clk_i);
    while (plan_sb.plan_words.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic gbop_pkg::in_t make_descriptor(bit last);
    gbop_pkg::in_t d;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5)       d.size_bytes = '0;
    else if (pick < 70) d.size_bytes = $urandom_range(1, 300);
    else if (pick < 75) d.size_bytes = '1;
    else                d.size_bytes = $urandom;
    if ($urandom_range(3) == 0) begin
      d.birth_step = 10'($urandom_range(1023));
      d.death_step = 10'($urandom_range(1023));
    end else begin
      d.birth_step = 10'($urandom_range(40));
      d.death_step = 10'(d.birth_step + $urandom_range(12));
    end
    d.view_flag = ($urandom_range(99) < 15);
    d.last_item = last;
    return d;
  endfunction

  function automatic gbop_pkg::in_t fixed_descriptor(logic [31:0] s, logic [9:0] b,
                                                     logic [9:0] e, logic v, logic last);
    gbop_pkg::in_t d;
    d.size_bytes = s; d.birth_step = b; d.death_step = e;
    d.view_flag = v; d.last_item = last;
    return d;
  endfunction

  task automatic random_batches(int unsigned num_items);
    int unsigned left, n;
    left = num_items;
    while (left > 0) begin
      n = $urandom_range(1, 8);
      if (n > left) n = left;
      for (int unsigned k = 0; k < n; k++) send_descriptor(make_descriptor(k == n - 1));
      left -= n;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) plan_sb.check_word(out_word_o);
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    plan_sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_arena(CAP_MAX);
    send_idle_pct = 21;
    recv_idle_pct = 45;
    // Widest buffer alone, full lifetime.
    send_descriptor(fixed_descriptor('1, 10'd0, 10'd1023, 1'b0, 1'b1));
    // Mixed batch: empty buffer, view, clashing lifetimes, birth after death.
    send_descriptor(fixed_descriptor(32'd100, 10'd0, 10'd5, 1'b0, 1'b0));
    send_descriptor(fixed_descriptor(32'd0, 10'd0, 10'd5, 1'b0, 1'b0));
    send_descriptor(fixed_descriptor(32'd200, 10'd0, 10'd5, 1'b1, 1'b0));
    send_descriptor(fixed_descriptor(32'd100, 10'd3, 10'd9, 1'b0, 1'b0));
    send_descriptor(fixed_descriptor(32'd50, 10'd6, 10'd2, 1'b0, 1'b0));
    send_descriptor(fixed_descriptor('1, 10'd4, 10'd4, 1'b0, 1'b0));
    send_descriptor(fixed_descriptor(32'd37, 10'd1023, 10'd1023, 1'b0, 1'b1));
    // Nothing takes storage, so the peak stays zero.
    send_descriptor(fixed_descriptor('1, 10'd1023, 10'd0, 1'b1, 1'b0));
    send_descriptor(fixed_descriptor(32'd0, 10'd0, 10'd0, 1'b0, 1'b1));
    // Equal sizes stay in load order and stack up.
    send_descriptor(fixed_descriptor(32'd16, 10'd0, 10'd0, 1'b0, 1'b0));
    send_descriptor(fixed_descriptor(32'd17, 10'd0, 10'd0, 1'b0, 1'b0));
    send_descriptor(fixed_descriptor(32'd16, 10'd0, 10'd0, 1'b0, 1'b1));
    drain_plans();

    write_arena('0);
    send_idle_pct = 45;
    recv_idle_pct = 21;
    random_batches(30);
    drain_plans();

    write_arena(39'd1024);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // The receiver holds off for a long stretch while batches keep arriving.
    hold_left = 3000;
    random_batches(20);
    // A batch longer than the store: the extra words are dropped.
    for (int unsigned k = 0; k < DEPTH + 2; k++) begin
      gbop_pkg::in_t d;
      d = make_descriptor(k == DEPTH + 1);
      d.size_bytes = $urandom_range(0, 200);
      send_descriptor(d);
    end
    drain_plans();

    write_arena(39'h40_0000_0000);
    random_batches(10);
    drain_plans();

    $display("covered %0d descriptors in %0d batches, %0d plan words checked",
             descriptors_sent, plan_sb.batches, plan_sb.words_checked);
    $display("capacities swept from zero to all ones, %0d mismatches", plan_sb.mismatches);
    if (plan_sb.mismatches == 0 && plan_sb.plan_words.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
src/gbop_pkg.sv
src/gbop_ram.sv
src/gbop_fifo.sv
src/gbop_front.sv
src/gbop_engine.sv
src/greedy_buffer_offset_planner_unit.sv
tb/testbench.sv
